### design/ial_pkg.sv
// ial_pkg: shared types, codes and character helpers for the indent-aware lexer.
// No dependencies; used by every design file.
package ial_pkg;

  localparam int STACK_DEPTH     = 16;
  localparam int CNT_W           = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W           = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int KEYWORD_MAX_LEN = 9;
  localparam int WLEN_W          = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int WIDX_W          = $clog2(KEYWORD_MAX_LEN);
  localparam int KW_W            = 8 * KEYWORD_MAX_LEN;
  localparam int KW_N            = 22;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [4:0] T_BSTART = 5'd0;
  localparam logic [4:0] T_BEND   = 5'd1;
  localparam logic [4:0] T_END    = 5'd2;
  localparam logic [4:0] T_IDENT  = 5'd3;
  localparam logic [4:0] T_NUMBER = 5'd4;
  localparam logic [4:0] T_TEXT   = 5'd5;
  localparam logic [4:0] T_PERIOD = 5'd6;
  localparam logic [4:0] T_COLON  = 5'd7;
  localparam logic [4:0] T_COMMA  = 5'd8;
  localparam logic [4:0] T_KW0    = 5'd9;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_CHAR    = 3'd1;
  localparam logic [2:0] E_COMMENT = 3'd2;
  localparam logic [2:0] E_STRING  = 3'd3;
  localparam logic [2:0] E_DEEP    = 3'd4;

  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_LPAREN = 8'h28;
  localparam logic [7:0] C_RPAREN = 8'h29;
  localparam logic [7:0] C_UNDER  = 8'h5F;
  localparam logic [7:0] C_DASH   = 8'h2D;
  localparam logic [7:0] C_ZERO   = 8'h30;

  localparam logic [KW_W-1:0] KW_TEXT [KW_N] = '{
    KW_W'("define"), KW_W'("as"), KW_W'("set"), KW_W'("let"), KW_W'("be"),
    KW_W'("to"), KW_W'("or"), KW_W'("if"), KW_W'("and"), KW_W'("true"),
    KW_W'("false"), KW_W'("otherwise"), KW_W'("times"), KW_W'("minus"),
    KW_W'("plus"), KW_W'("over"), KW_W'("with"), KW_W'("return"),
    KW_W'("mod"), KW_W'("while"), KW_W'("of"), KW_W'("print")
  };
  localparam logic [3:0] KW_LEN [KW_N] = '{
    4'd6, 4'd2, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd4, 4'd5,
    4'd9, 4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd6, 4'd3, 4'd5, 4'd2, 4'd5
  };

  typedef struct packed {
    logic [4:0]  token_type;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [2:0]  error_code;
    logic        last;
  } tok_t;

  // mark: no token, sets last on the token before it
  typedef struct packed {
    logic mark;
    tok_t tok;
  } q_entry_t;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || is_digit(c) || c == C_UNDER || c == C_DASH;
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return c == 8'h0A || c == 8'h00;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == C_TAB || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  // word text is right-justified, first byte highest
  function automatic logic [4:0] kw_lookup(input logic [KEYWORD_MAX_LEN-1:0][7:0] buf_in,
                                           input logic [WLEN_W-1:0] len);
    logic [KW_W-1:0] w;
    logic [4:0]      t;
    w = '0;
    t = T_IDENT;
    for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
      if (WLEN_W'(i) < len) w = {w[KW_W-9:0], buf_in[i]};
    end
    if (len <= WLEN_W'(KEYWORD_MAX_LEN)) begin
      for (int k = KW_N - 1; k >= 0; k--) begin
        if (WLEN_W'(KW_LEN[k]) == len && KW_TEXT[k] == w) t = T_KW0 + 5'(k);
      end
    end
    return t;
  endfunction

endpackage

### design/ial_queue.sv
// ial_queue: short FIFO of token words between the scanner and the output stage.
// Depends on ial_pkg.
module ial_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ial_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output ial_pkg::q_entry_t head,
  output logic              empty
);

  ial_pkg::q_entry_t mem [ial_pkg::QUEUE_DEPTH];
  logic [ial_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [ial_pkg::QPTR_W:0]   count;

  assign full  = count == (ial_pkg::QPTR_W+1)'(ial_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (ial_pkg::QPTR_W+1)'(push) - (ial_pkg::QPTR_W+1)'(pop);
    end
  end

endmodule

### design/ial_front.sv
// ial_front: byte scanner; tracks mode, indentation stack and word text, pushes tokens.
// Depends on ial_pkg; feeds ial_queue.
module ial_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tuser,
  input  logic              q_full,
  output logic              q_push,
  output ial_pkg::q_entry_t q_data
);

  typedef enum logic [2:0] {F_IDLE, F_BODY, F_POP, F_DRAIN, F_HALT} fstate_t;
  typedef enum logic [2:0] {M_LINE, M_BODY, M_COMMENT, M_STRING, M_WORD, M_NUMBER} mode_t;

  fstate_t state, state_next;
  mode_t   mode, mode_next;
  logic [7:0]  tab_count, tab_count_next;
  logic [7:0]  stack [ial_pkg::STACK_DEPTH];
  logic [ial_pkg::CNT_W-1:0] stack_cnt, stack_cnt_next;
  logic [ial_pkg::KEYWORD_MAX_LEN-1:0][7:0] word_buf;
  logic [ial_pkg::WLEN_W-1:0] word_len, word_len_next;
  logic [15:0] tsp, tsp_next, byte_pos, byte_pos_next, line_cnt, line_cnt_next;
  logic [7:0]  quote, quote_next, held, held_next;
  logic        has_tok, has_tok_next;

  logic        stk_we;
  logic [7:0]  wb_d;
  logic        wb_we;
  logic [ial_pkg::WIDX_W-1:0] wb_idx;

  logic        acc, go, eos;
  logic [7:0]  c, bc;
  logic [7:0]  top;
  logic        push_cond, stk_full;
  logic [15:0] span;
  ial_pkg::tok_t tk;

  assign acc = s_tvalid && s_tready;
  assign go  = !q_full;
  assign eos = s_tuser;
  assign c   = ial_pkg::lower(s_tdata);
  assign s_tready = (state == F_IDLE || state == F_HALT) && !q_full;
  assign top = stack[ial_pkg::IDX_W'(stack_cnt - 1'b1)];
  assign push_cond = (stack_cnt != '0) ? (tab_count > top) : (tab_count != 8'd0);
  assign stk_full  = stack_cnt == ial_pkg::CNT_W'(ial_pkg::STACK_DEPTH);
  assign span = byte_pos - tsp;

  always_comb begin
    state_next = state; mode_next = mode; tab_count_next = tab_count;
    stack_cnt_next = stack_cnt; word_len_next = word_len; tsp_next = tsp;
    byte_pos_next = byte_pos; line_cnt_next = line_cnt; quote_next = quote;
    held_next = held; has_tok_next = has_tok;
    stk_we = 1'b0; wb_we = 1'b0; wb_idx = '0; wb_d = c;
    q_push = 1'b0;
    q_data = '0;
    tk = '0;
    tk.line_number = line_cnt;
    bc = (state == F_BODY) ? held : c;

    unique case (state)
      F_IDLE: begin
        if (acc && eos) begin
          unique case (mode) inside
            M_LINE: begin
              state_next = F_DRAIN;
              if (tab_count != 8'd0 && push_cond) begin
                q_push = 1'b1;
                if (stk_full) begin
                  tk.token_start = byte_pos; tk.error_code = ial_pkg::E_DEEP;
                  tk.last = 1'b1; state_next = F_HALT;
                end else begin
                  stk_we = 1'b1; stack_cnt_next = stack_cnt + 1'b1;
                end
              end
            end
            M_COMMENT, M_STRING: begin
              q_push = 1'b1; tk.token_start = byte_pos; tk.last = 1'b1;
              tk.error_code = (mode == M_COMMENT) ? ial_pkg::E_COMMENT : ial_pkg::E_STRING;
              state_next = F_HALT;
            end
            M_WORD, M_NUMBER: begin
              q_push = 1'b1;
              tk.token_type = (mode == M_WORD) ? ial_pkg::kw_lookup(word_buf, word_len)
                                               : ial_pkg::T_NUMBER;
              tk.token_start = tsp; tk.token_length = span;
              state_next = F_DRAIN;
            end
            default: state_next = F_DRAIN;
          endcase
        end else if (acc) begin
          unique case (mode) inside
            M_LINE: begin
              if (c == ial_pkg::C_TAB) begin
                if (tab_count != 8'hFF) tab_count_next = tab_count + 8'd1;
                byte_pos_next = byte_pos + 16'd1;
              end else begin
                held_next = c;
                if (push_cond) begin
                  q_push = 1'b1;
                  if (stk_full) begin
                    tk.token_start = byte_pos; tk.error_code = ial_pkg::E_DEEP;
                    tk.last = 1'b1; state_next = F_HALT;
                  end else begin
                    stk_we = 1'b1; stack_cnt_next = stack_cnt + 1'b1;
                    has_tok_next = 1'b1; state_next = F_BODY;
                  end
                end else begin
                  state_next = F_POP;
                end
              end
            end
            M_COMMENT: begin
              if (c == ial_pkg::C_RPAREN) mode_next = M_BODY;
              else if (ial_pkg::is_term(c)) begin
                q_push = 1'b1; tk.token_start = byte_pos; tk.last = 1'b1;
                tk.error_code = ial_pkg::E_COMMENT; state_next = F_HALT;
              end
              byte_pos_next = byte_pos + 16'd1;
            end
            M_STRING: begin
              if (c == quote) begin
                q_push = 1'b1; tk.token_type = ial_pkg::T_TEXT; tk.token_start = tsp;
                tk.token_length = span; tk.last = 1'b1; mode_next = M_BODY;
              end else if (ial_pkg::is_term(c)) begin
                q_push = 1'b1; tk.token_start = byte_pos; tk.last = 1'b1;
                tk.error_code = ial_pkg::E_STRING; state_next = F_HALT;
              end
              byte_pos_next = byte_pos + 16'd1;
            end
            M_WORD, M_NUMBER: begin
              if (mode == M_WORD && ial_pkg::is_ident(c)) begin
                if (word_len < ial_pkg::WLEN_W'(ial_pkg::KEYWORD_MAX_LEN)) begin
                  wb_we = 1'b1; wb_idx = ial_pkg::WIDX_W'(word_len);
                end
                if (word_len <= ial_pkg::WLEN_W'(ial_pkg::KEYWORD_MAX_LEN))
                  word_len_next = word_len + 1'b1;
                byte_pos_next = byte_pos + 16'd1;
              end else if (mode == M_NUMBER && ial_pkg::is_digit(c)) begin
                byte_pos_next = byte_pos + 16'd1;
              end else begin
                q_push = 1'b1;
                tk.token_type = (mode == M_WORD) ? ial_pkg::kw_lookup(word_buf, word_len)
                                                 : ial_pkg::T_NUMBER;
                tk.token_start = tsp; tk.token_length = span;
                held_next = c; has_tok_next = 1'b1; state_next = F_BODY;
              end
            end
            default: ;
          endcase
        end
      end
      F_POP: begin
        if (go) begin
          if (stack_cnt != '0 && tab_count < top) begin
            q_push = 1'b1; tk.token_type = ial_pkg::T_BEND;
            stack_cnt_next = stack_cnt - 1'b1; has_tok_next = 1'b1;
          end else begin
            state_next = F_BODY;
          end
        end
      end
      F_DRAIN: begin
        if (go) begin
          q_push = 1'b1;
          if (stack_cnt != '0) begin
            tk.token_type = ial_pkg::T_BEND; stack_cnt_next = stack_cnt - 1'b1;
          end else begin
            // end token; back to the start-of-source state
            tk.token_type = ial_pkg::T_END; tk.last = 1'b1;
            state_next = F_IDLE; mode_next = M_LINE; tab_count_next = 8'd0;
            word_len_next = '0; tsp_next = '0; byte_pos_next = '0;
            line_cnt_next = 16'd1; quote_next = 8'd0; has_tok_next = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // one body byte, either the accepted one or the held one
    if ((state == F_IDLE && acc && !eos && mode == M_BODY) || (state == F_BODY && go)) begin
      mode_next = M_BODY;
      q_push = 1'b1;
      tk.token_start = byte_pos;
      tk.token_length = 16'd1;
      tk.last = 1'b1;
      if (ial_pkg::is_term(bc)) begin
        q_push = 1'b0;
        if (line_cnt != 16'hFFFF) line_cnt_next = line_cnt + 16'd1;
        mode_next = M_LINE; tab_count_next = 8'd0;
      end else if (ial_pkg::is_blank(bc)) begin
        q_push = 1'b0;
      end else if (bc == ial_pkg::C_LPAREN) begin
        q_push = 1'b0; mode_next = M_COMMENT;
      end else if (bc == 8'h3A) begin
        tk.token_type = ial_pkg::T_COLON;
      end else if (bc == 8'h2E) begin
        tk.token_type = ial_pkg::T_PERIOD;
      end else if (bc == 8'h2C) begin
        tk.token_type = ial_pkg::T_COMMA;
      end else if (bc == 8'h22 || bc == 8'h27) begin
        q_push = 1'b0; quote_next = bc; tsp_next = byte_pos + 16'd1; mode_next = M_STRING;
      end else if (bc == ial_pkg::C_ZERO) begin
        tk.token_type = ial_pkg::T_NUMBER;
      end else if (ial_pkg::is_digit(bc)) begin
        q_push = 1'b0; tsp_next = byte_pos; mode_next = M_NUMBER;
      end else if (ial_pkg::is_ident(bc)) begin
        q_push = 1'b0; tsp_next = byte_pos; mode_next = M_WORD;
        wb_we = 1'b1; wb_idx = '0; wb_d = bc; word_len_next = ial_pkg::WLEN_W'(1);
      end else begin
        tk.token_length = 16'd0; tk.error_code = ial_pkg::E_CHAR;
      end
      if (tk.error_code != ial_pkg::E_NONE) state_next = F_HALT;
      else state_next = F_IDLE;
      // earlier tokens of this byte get their last flag through a mark
      if (!q_push && has_tok) begin
        q_push = 1'b1; q_data.mark = 1'b1;
      end
      has_tok_next = 1'b0;
      byte_pos_next = byte_pos + 16'd1;
    end

    q_data.tok = tk;
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack[ial_pkg::IDX_W'(stack_cnt)] <= tab_count;
    if (wb_we) word_buf[wb_idx] <= wb_d;
    held <= held_next;
    if (rst) begin
      state <= F_IDLE; mode <= M_LINE; tab_count <= 8'd0; stack_cnt <= '0;
      word_len <= '0; tsp <= '0; byte_pos <= '0; line_cnt <= 16'd1;
      quote <= 8'd0; has_tok <= 1'b0;
    end else begin
      state <= state_next; mode <= mode_next; tab_count <= tab_count_next;
      stack_cnt <= stack_cnt_next; word_len <= word_len_next; tsp <= tsp_next;
      byte_pos <= byte_pos_next; line_cnt <= line_cnt_next; quote <= quote_next;
      has_tok <= has_tok_next;
    end
  end

endmodule

### design/ial_back.sv
// ial_back: output stage; holds one token until its last flag is known, then drives the bus.
// Depends on ial_pkg; drains ial_queue.
module ial_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  ial_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [55:0]       m_tdata,
  output logic              m_tlast
);

  ial_pkg::tok_t pend, pend_next, outr, outr_next;
  logic pend_v, pend_v_next, out_v, out_v_next;
  logic out_free, have;

  assign out_free = !out_v || m_tready;
  assign have = !q_empty;

  always_comb begin
    pend_next = pend; pend_v_next = pend_v; outr_next = outr;
    out_v_next = out_v && !m_tready;
    q_pop = 1'b0;
    if (out_free && pend_v && pend.last) begin
      outr_next = pend; out_v_next = 1'b1; pend_v_next = 1'b0;
      if (have && !q_head.mark) begin
        pend_next = q_head.tok; pend_v_next = 1'b1; q_pop = 1'b1;
      end
    end else if (out_free && pend_v && have) begin
      outr_next = pend; out_v_next = 1'b1; q_pop = 1'b1;
      if (q_head.mark) begin
        outr_next.last = 1'b1; pend_v_next = 1'b0;
      end else begin
        pend_next = q_head.tok;
      end
    end else if (!pend_v && have) begin
      q_pop = 1'b1;
      if (!q_head.mark) begin
        pend_next = q_head.tok; pend_v_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    outr <= outr_next;
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      pend_v <= pend_v_next;
      out_v  <= out_v_next;
    end
  end

  assign m_tvalid = out_v;
  assign m_tlast  = outr.last;
  assign m_tdata  = {outr.error_code, outr.line_number, outr.token_length,
                     outr.token_start, outr.token_type};

endmodule

### design/indent_aware_lexer_top.sv
// indent_aware_lexer_top: lexer top level; scanner, token queue and output stage.
// Depends on ial_pkg, ial_front, ial_queue, ial_back.
//
//  channel | dir | tdata                 | tuser    | tlast
//  s_      | in  | char_code[7:0]        | func     | -
//  m_      | out | type,start,len,line,err | -      | last result of the word
//
// A byte that ends a word or number is held and scanned again as a body byte once
// the word token is pushed. The first non-tab byte of a line either opens a block
// or passes through the scanner pop loop, which pushes one block end per closed level.
// End of source pushes a block end per open block, then the end token. The scanner
// stalls while the four-entry token queue is full; the output stage holds one token
// back until its last flag is known. Synchronous reset returns to the start-of-source
// state. After an error the block swallows every word until reset.
module indent_aware_lexer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code[7:0]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // token_type[4:0], token_start[20:5], token_length[36:21],
                                 // line_number[52:37], error_code[55:53]
  output logic        m_tlast    // last
);

  ial_pkg::q_entry_t push_data, head;
  logic push, full, pop, empty;

  ial_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_full(full), .q_push(push), .q_data(push_data)
  );

  ial_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .head, .empty
  );

  ial_back u_back (
    .clk, .rst, .q_empty(empty), .q_head(head), .q_pop(pop),
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule

### design/ial_checker.sv
// ial_checker: port-level assertions for the lexer top level, bound in below.
// Depends on ial_pkg and the indent_aware_lexer_top ports.
module ial_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[55:53] != ial_pkg::E_NONE |-> m_tlast
      && m_tdata[4:0] == ial_pkg::T_BSTART && m_tdata[36:21] == 16'd0)
    else $error("error word malformed");

  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:0] == ial_pkg::T_END |-> m_tlast
      && m_tdata[55:53] == ial_pkg::E_NONE && m_tdata[20:5] == 16'd0)
    else $error("end word malformed");

  a_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[52:37] != 16'd0)
    else $error("line number zero");

endmodule

bind indent_aware_lexer_top ial_checker u_ial_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
